@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the chunk filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication with the same reset handling.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/pccf_pkg.sv @@
// Package with the shared types and constants of the PNG critical chunk filter.
`timescale 1ns / 1ps
`default_nettype none

package pccf_pkg;

  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned IDX_W      = $clog2(HDR_BYTES);
  // One header burst plus the body bytes that arrive while it drains.
  localparam int unsigned FIFO_DEPTH = 9;

  localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR     = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT     = 32'h49444154;
  localparam logic [31:0] TYPE_PLTE     = 32'h504C5445;
  localparam logic [31:0] TYPE_IEND     = 32'h49454E44;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIG  = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  // One queued job: either a burst of eight held bytes or a single result.
  typedef struct packed {
    logic        burst;
    logic [63:0] bytes;     // burst: oldest byte highest; single: byte in [7:0]
    logic        has_byte;
    status_e     status;    // goes on the last result of the job
  } job_t;

  function automatic logic is_critical(logic [31:0] type_word);
    return (type_word == TYPE_IHDR) || (type_word == TYPE_IDAT) ||
           (type_word == TYPE_PLTE) || (type_word == TYPE_IEND);
  endfunction

endpackage

`default_nettype wire

@@ hdl/png_critical_chunk_filter.sv @@
// PNG critical chunk filter: top level with parser, job queue and output sequencer.
// Usage: the file enters one byte per transaction on the s_axis side, with tlast
// set on its final byte. The signature is echoed if valid, chunks of type IHDR,
// IDAT, PLTE and IEND pass through whole, and all other chunks are dropped.
// Each master-side transaction carries one result: the byte in tdata, has_byte
// and status in tuser, and tlast on the last result caused by one input byte.
// A result with has_byte low carries only an error status on a byte with no output.
// An accepted byte is queued and then loaded into the output register. Throughput:
// one input byte per cycle while the queue is not full. The eighth byte of a kept
// header yields eight results, drained one per cycle by the output sequencer while
// the receiver is ready; the output register sets the sustained rate of one result
// per cycle. A queue of FifoDepth jobs lets the parser keep accepting while a burst
// drains; nine jobs hold one burst plus the body bytes that arrive behind it.
// When the receiver stalls, the output register holds, the queue fills, and
// s_axis_tready_o drops once the queue is full; nothing is lost.
// Reset clears the parser to expect a signature and empties the queue and the
// output register. After a bad signature the parser ignores bytes until the
// end of the file; any tlast starts a new file on the next byte.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module png_critical_chunk_filter #(
  parameter int unsigned FifoDepth = pccf_pkg::FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // end_of_file
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] data_byte
  output logic [2:0]      m_axis_tuser_o,   // [0] has_byte, [2:1] status
  output logic            m_axis_tlast_o    // run_last
);

  pccf_pkg::job_t push_job;
  pccf_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           fifo_empty;
  logic           fifo_full;

  // The parser classifies every byte and queues at most one job per byte.
  pccf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_eof_i   (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .full_i     (fifo_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  pccf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  // The sequencer turns a burst job into eight results, one per transaction.
  pccf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // A nonzero status only ever rides on the last result of an input byte.
  `ASSERT_IMPL(a_status_on_last, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o[2:1] != pccf_pkg::ST_OK), m_axis_tlast_o,
    "status on a result that is not last")
  // A result without a byte exists only to carry an error status.
  `ASSERT_IMPL(a_empty_has_status, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0],
    (m_axis_tuser_o[2:1] != pccf_pkg::ST_OK) && m_axis_tlast_o && (m_axis_tdata_o == 8'h00),
    "empty result without status")
  // The status code never takes the unused encoding.
  `ASSERT_IMPL(a_status_code, clk_i, rst_ni, m_axis_tvalid_o,
    m_axis_tuser_o[2:1] <= pccf_pkg::ST_TRUNC, "illegal status code")

endmodule

`default_nettype wire

@@ hdl/pccf_front.sv @@
// Front end: parses the byte stream and turns each byte into at most one job.
`timescale 1ns / 1ps
`default_nettype none

module pccf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_eof_i,
  output logic                in_ready_o,
  input  wire logic           full_i,
  output logic                push_o,
  output pccf_pkg::job_t      job_o
);

  typedef enum logic [3:0] {
    PH_SIG  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [pccf_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic [63:0]                    hdr_q, hdr_d;
  logic [32:0]                    rem_q, rem_d;
  logic                           keep_q, keep_d;
  logic                           accept;
  logic                           pos_full;
  logic                           body_done;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign pos_full   = (pos_q == pccf_pkg::IDX_W'(pccf_pkg::HDR_BYTES - 1));
  assign body_done  = (rem_q == 33'd1);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    rem_d   = rem_q;
    keep_d  = keep_q;
    push_o  = 1'b0;
    job_o   = '{burst: 1'b0, bytes: '0, has_byte: 1'b0, status: pccf_pkg::ST_OK};

    if (accept) begin
      case (phase_q)
        PH_SIG: begin
          hdr_d = {hdr_q[55:0], in_byte_i};
          if (pos_full) begin
            pos_d  = '0;
            push_o = 1'b1;
            if (hdr_d == pccf_pkg::PNG_SIGNATURE) begin
              job_o.burst    = 1'b1;
              job_o.bytes    = hdr_d;
              job_o.has_byte = 1'b1;
              phase_d        = PH_HDR;
            end else begin
              job_o.status = pccf_pkg::ST_BAD_SIG;
              phase_d      = PH_ERR;
            end
          end else begin
            pos_d = pos_q + 1'b1;
            if (in_eof_i) begin
              push_o       = 1'b1;
              job_o.status = pccf_pkg::ST_TRUNC;
            end
          end
        end
        PH_HDR: begin
          hdr_d = {hdr_q[55:0], in_byte_i};
          if (pos_full) begin
            pos_d   = '0;
            keep_d  = pccf_pkg::is_critical(hdr_d[31:0]);
            rem_d   = {1'b0, hdr_d[63:32]} + 33'd4;
            phase_d = PH_BODY;
            if (keep_d) begin
              push_o         = 1'b1;
              job_o.burst    = 1'b1;
              job_o.bytes    = hdr_d;
              job_o.has_byte = 1'b1;
            end
          end else begin
            pos_d = pos_q + 1'b1;
          end
          if (in_eof_i) begin
            push_o       = 1'b1;
            job_o.status = pccf_pkg::ST_TRUNC;
          end
        end
        PH_BODY: begin
          rem_d = rem_q - 33'd1;
          if (body_done) begin
            phase_d = PH_HDR;
            pos_d   = '0;
          end else if (in_eof_i) begin
            job_o.status = pccf_pkg::ST_TRUNC;
          end
          job_o.bytes[7:0] = keep_q ? in_byte_i : 8'h00;
          job_o.has_byte   = keep_q;
          push_o           = keep_q || (job_o.status != pccf_pkg::ST_OK);
        end
        PH_ERR: begin
          // Bytes are dropped until the end of the file.
        end
        default: begin
          phase_d = PH_ERR;
        end
      endcase

      // The end of the file always starts a fresh file on the next byte.
      if (in_eof_i) begin
        phase_d = PH_SIG;
        pos_d   = '0;
        keep_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      pos_q   <= '0;
      keep_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      keep_q  <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

@@ hdl/pccf_fifo.sv @@
// Short job queue between the parser and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pccf_fifo #(
  parameter int unsigned Depth = pccf_pkg::FIFO_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pccf_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output pccf_pkg::job_t      head_job_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pccf_pkg::job_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CntW'(Depth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/pccf_back.sv @@
// Back end: expands queued jobs into results and holds them in the output register.
`timescale 1ns / 1ps
`default_nettype none

module pccf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pccf_pkg::job_t head_job_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic [2:0]          out_user_o,
  output logic                out_last_o
);

  logic [pccf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       valid_q;
  logic [7:0]                 byte_q;
  logic [2:0]                 user_q;
  logic                       last_q;
  logic                       load;
  logic                       res_last;
  logic [7:0]                 res_byte;
  pccf_pkg::status_e          res_status;

  assign load = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    res_last   = !head_job_i.burst ||
                 (idx_q == pccf_pkg::IDX_W'(pccf_pkg::HDR_BYTES - 1));
    res_byte   = head_job_i.burst ?
                 head_job_i.bytes[8 * (pccf_pkg::HDR_BYTES - 1 - idx_q) +: 8] :
                 head_job_i.bytes[7:0];
    res_status = res_last ? head_job_i.status : pccf_pkg::ST_OK;
    idx_d      = idx_q;
    if (load) begin
      idx_d = res_last ? '0 : idx_q + 1'b1;
    end
  end

  assign pop_o = load && res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= res_byte;
      user_q <= {res_status, head_job_i.has_byte};
      last_q <= res_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire
